### rtl/itr_pkg.sv
// itr_pkg: shared types, constants and the control store for the radix text printer
// holds the microprogram, control word and status structs, and the alphabet character test
// no dependencies
package itr_pkg;

  // configuration file shape
  localparam int CFG_WORDS     = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int ADDR_BITS     = 6;   // byte address into the alphabet
  localparam int CNT_BITS      = 7;   // scan index / reciprocal step counter
  localparam int RADIX_BITS    = 7;   // radix 2..64
  localparam int DIGIT_BITS    = 6;   // digit 0..63
  localparam int PC_BITS       = 4;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef logic [3:0] op_t;
  typedef logic [3:0] cond_t;
  typedef logic [PC_BITS-1:0] pc_t;

  // datapath operations
  localparam op_t OP_NOP   = 4'd0;
  localparam op_t OP_LOAD  = 4'd1;
  localparam op_t OP_MUL1  = 4'd2;
  localparam op_t OP_MUL2  = 4'd3;
  localparam op_t OP_FIX   = 4'd4;
  localparam op_t OP_SIGN  = 4'd5;
  localparam op_t OP_POP   = 4'd6;
  localparam op_t OP_EMIT  = 4'd7;
  localparam op_t OP_VCLR  = 4'd8;
  localparam op_t OP_VSCAN = 4'd9;
  localparam op_t OP_VLEN  = 4'd10;
  localparam op_t OP_VREC  = 4'd11;

  // jump conditions
  localparam cond_t C_NEVER     = 4'd0;
  localparam cond_t C_ALWAYS    = 4'd1;
  localparam cond_t C_DIRTY     = 4'd2;
  localparam cond_t C_NOGO      = 4'd3;
  localparam cond_t C_BAD       = 4'd4;
  localparam cond_t C_MAGNZ     = 4'd5;
  localparam cond_t C_SPNZ      = 4'd6;
  localparam cond_t C_SCAN_MORE = 4'd7;
  localparam cond_t C_REC_MORE  = 4'd8;

  // program addresses
  localparam pc_t A_WAIT0 = 4'd0;
  localparam pc_t A_WAIT1 = 4'd1;
  localparam pc_t A_CHK   = 4'd2;
  localparam pc_t A_MUL1  = 4'd3;
  localparam pc_t A_MUL2  = 4'd4;
  localparam pc_t A_FIX   = 4'd5;
  localparam pc_t A_TEST  = 4'd6;
  localparam pc_t A_SIGN  = 4'd7;
  localparam pc_t A_POP   = 4'd8;
  localparam pc_t A_EMIT  = 4'd9;
  localparam pc_t A_DONE  = 4'd10;
  localparam pc_t A_VCLR  = 4'd11;
  localparam pc_t A_VSCAN = 4'd12;
  localparam pc_t A_VLEN  = 4'd13;
  localparam pc_t A_VREC  = 4'd14;
  localparam pc_t A_VDONE = 4'd15;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic dirty;
    logic bad;
    logic scan_more;
    logic rec_more;
  } alph_stat_t;

  typedef struct packed {
    logic nogo;
    logic mag_nz;
    logic sp_nz;
  } dp_stat_t;

  // control store: one word per step
  function automatic ctrl_t ucode(input pc_t addr);
    ctrl_t w;
    unique case (addr)
      A_WAIT0: w = '{OP_NOP,   C_DIRTY,     A_VCLR};
      A_WAIT1: w = '{OP_LOAD,  C_NOGO,      A_WAIT0};
      A_CHK:   w = '{OP_NOP,   C_BAD,       A_WAIT0};
      A_MUL1:  w = '{OP_MUL1,  C_NEVER,     A_WAIT0};
      A_MUL2:  w = '{OP_MUL2,  C_NEVER,     A_WAIT0};
      A_FIX:   w = '{OP_FIX,   C_NEVER,     A_WAIT0};
      A_TEST:  w = '{OP_NOP,   C_MAGNZ,     A_MUL1};
      A_SIGN:  w = '{OP_SIGN,  C_NEVER,     A_WAIT0};
      A_POP:   w = '{OP_POP,   C_NEVER,     A_WAIT0};
      A_EMIT:  w = '{OP_EMIT,  C_SPNZ,      A_POP};
      A_DONE:  w = '{OP_NOP,   C_ALWAYS,    A_WAIT0};
      A_VCLR:  w = '{OP_VCLR,  C_NEVER,     A_WAIT0};
      A_VSCAN: w = '{OP_VSCAN, C_SCAN_MORE, A_VSCAN};
      A_VLEN:  w = '{OP_VLEN,  C_NEVER,     A_WAIT0};
      A_VREC:  w = '{OP_VREC,  C_REC_MORE,  A_VREC};
      A_VDONE: w = '{OP_NOP,   C_ALWAYS,    A_WAIT0};
      default: w = '{OP_NOP,   C_ALWAYS,    A_WAIT0};
    endcase
    return w;
  endfunction

  // ascii letter or decimal digit
  function automatic logic is_alnum(input logic [7:0] c);
    return (c > 8'd47 && c < 8'd58) || (c > 8'd64 && c < 8'd91) ||
           (c > 8'd96 && c < 8'd123);
  endfunction

endpackage

### rtl/itr_sequencer.sv
// itr_sequencer: step counter, control store lookup and conditional jumps
// depends on itr_pkg
module itr_sequencer
  import itr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  alph_stat_t astat,
  input  dp_stat_t   dstat,
  output pc_t        pc,
  output ctrl_t      ctrl
);

  pc_t  pc_next;
  logic taken;

  // control word for the current step
  always_comb ctrl = ucode(pc);

  // jump condition select
  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_DIRTY:     taken = astat.dirty;
      C_NOGO:      taken = dstat.nogo;
      C_BAD:       taken = astat.bad;
      C_MAGNZ:     taken = dstat.mag_nz;
      C_SPNZ:      taken = dstat.sp_nz;
      C_SCAN_MORE: taken = astat.scan_more;
      C_REC_MORE:  taken = astat.rec_more;
      default:     taken = 1'b0;
    endcase
    pc_next = taken ? ctrl.target : PC_BITS'(pc + 1'b1);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_WAIT0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### rtl/itr_alphabet.sv
// itr_alphabet: alphabet registers, validation scan and radix reciprocal
// depends on itr_pkg; driven by the sequencer's control word
module itr_alphabet
  import itr_pkg::*;
#(
  parameter int ALPHABET_BYTES = 64,
  parameter int NUMBER_BITS    = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  op_t                      op,
  input  logic [ADDR_BITS-1:0]     rd_addr,
  output logic [7:0]               rd_byte,
  output logic [RADIX_BITS-1:0]    radix,
  output logic [NUMBER_BITS-1:0]   recip,
  output alph_stat_t               astat
);

  logic [CFG_DATA_BITS-1:0] alph [CFG_WORDS];
  logic                     dirty;
  logic                     bad;
  logic [127:0]             seen;
  logic [CNT_BITS-1:0]      idx;
  logic [RADIX_BITS-1:0]    rrem;
  logic [ADDR_BITS-1:0]     addr;
  logic                     scan_end;
  logic [RADIX_BITS:0]      rsh;
  logic                     rge;
  logic [RADIX_BITS-1:0]    rrem_next;

  // single byte read port, shared by the scan and digit lookup
  always_comb begin
    addr     = (op == OP_VSCAN) ? idx[ADDR_BITS-1:0] : rd_addr;
    rd_byte  = alph[addr[ADDR_BITS-1:3]][{addr[2:0], 3'b000} +: 8];
    scan_end = (idx == CNT_BITS'(ALPHABET_BYTES)) || (rd_byte == 8'd0);
  end

  // one restoring step of 2^NUMBER_BITS / radix
  always_comb begin
    rsh       = {rrem, (idx == '0)};
    rge       = rsh >= {1'b0, radix};
    rrem_next = rge ? RADIX_BITS'(rsh - {1'b0, radix}) : rsh[RADIX_BITS-1:0];
  end

  always_comb begin
    astat.dirty     = dirty;
    astat.bad       = bad;
    astat.scan_more = !scan_end;
    astat.rec_more  = (idx != CNT_BITS'(NUMBER_BITS));
  end

  // register file and validation flags
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b1;
      bad   <= 1'b1;
      for (int k = 0; k < CFG_WORDS; k++) begin
        alph[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        alph[cfg_index] <= cfg_data;
      end
      unique case (op)
        OP_VCLR: begin
          bad <= 1'b0;
        end
        OP_VSCAN: begin
          if (!scan_end && (!is_alnum(rd_byte) || seen[rd_byte[6:0]])) begin
            bad <= 1'b1;
          end
        end
        OP_VLEN: begin
          if (idx < CNT_BITS'(2)) begin
            bad <= 1'b1;
          end
        end
        default: ;
      endcase
      // a write during a scan forces another pass
      if (cfg_we) begin
        dirty <= 1'b1;
      end else if (op == OP_VCLR) begin
        dirty <= 1'b0;
      end
    end
  end

  // scan state and reciprocal
  always_ff @(posedge clk) begin
    unique case (op)
      OP_VCLR: begin
        seen <= '0;
        idx  <= '0;
      end
      OP_VSCAN: begin
        if (!scan_end) begin
          seen[rd_byte[6:0]] <= 1'b1;
          idx                <= CNT_BITS'(idx + 1'b1);
        end
      end
      OP_VLEN: begin
        radix <= idx;
        idx   <= '0;
        rrem  <= '0;
      end
      OP_VREC: begin
        rrem  <= rrem_next;
        recip <= {recip[NUMBER_BITS-2:0], rge};
        idx   <= CNT_BITS'(idx + 1'b1);
      end
      default: ;
    endcase
  end

endmodule

### rtl/itr_datapath.sv
// itr_datapath: magnitude, reciprocal divide with correction, digit stack and output word
// depends on itr_pkg; driven by the sequencer's control word
module itr_datapath
  import itr_pkg::*;
#(
  parameter int NUMBER_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [NUMBER_BITS-1:0] number,
  input  op_t                           op,
  input  logic [RADIX_BITS-1:0]         radix,
  input  logic [NUMBER_BITS-1:0]        recip,
  input  logic [7:0]                    rd_byte,
  output logic [ADDR_BITS-1:0]          rd_addr,
  output dp_stat_t                      dstat,
  output logic [7:0]                    character,
  output logic                          last,
  output logic                          strobe
);

  localparam int SP_BITS  = $clog2(NUMBER_BITS + 1);
  localparam int IDX_BITS = $clog2(NUMBER_BITS);
  localparam int PROD_BITS = 2 * NUMBER_BITS;
  localparam int QR_BITS  = NUMBER_BITS + RADIX_BITS;

  logic                        go;
  logic [NUMBER_BITS-1:0]      raw;
  logic [NUMBER_BITS-1:0]      mag_in;
  logic [NUMBER_BITS-1:0]      mag;
  logic                        neg;
  logic [PROD_BITS-1:0]        prod;
  logic [NUMBER_BITS-1:0]      q;
  logic [QR_BITS-1:0]          qr;
  logic [NUMBER_BITS-1:0]      rem;
  logic                        rge;
  logic [DIGIT_BITS-1:0]       digit;
  logic [DIGIT_BITS-1:0]       stack [NUMBER_BITS];
  logic [SP_BITS-1:0]          sp;
  logic [SP_BITS-1:0]          sp_m1;
  logic [DIGIT_BITS-1:0]       dread;

  // accept and magnitude
  always_comb begin
    go     = start && !busy;
    raw    = number;
    mag_in = raw[NUMBER_BITS-1] ? NUMBER_BITS'(~raw + 1'b1) : raw;
  end

  // remainder is below twice the radix: one compare and subtract
  always_comb begin
    rem   = NUMBER_BITS'(mag - qr[NUMBER_BITS-1:0]);
    rge   = rem[7:0] >= {1'b0, radix};
    digit = rge ? DIGIT_BITS'(rem[7:0] - {1'b0, radix}) : rem[DIGIT_BITS-1:0];
    sp_m1 = SP_BITS'(sp - 1'b1);
  end

  always_comb begin
    rd_addr      = dread;
    dstat.nogo   = !go;
    dstat.mag_nz = (mag != '0);
    dstat.sp_nz  = (sp != '0);
  end

  // arithmetic registers and digit stack
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        if (go) begin
          mag <= mag_in;
          neg <= raw[NUMBER_BITS-1];
        end
      end
      OP_MUL1: prod <= PROD_BITS'(mag) * PROD_BITS'(recip);
      OP_MUL2: begin
        q  <= prod[PROD_BITS-1:NUMBER_BITS];
        qr <= QR_BITS'(prod[PROD_BITS-1:NUMBER_BITS]) * QR_BITS'(radix);
      end
      OP_FIX: begin
        stack[sp[IDX_BITS-1:0]] <= digit;
        mag <= rge ? NUMBER_BITS'(q + 1'b1) : q;
      end
      OP_POP: dread <= stack[sp_m1[IDX_BITS-1:0]];
      default: ;
    endcase
  end

  // output word
  always_ff @(posedge clk) begin
    unique case (op)
      OP_SIGN: begin
        character <= CHAR_MINUS;
        last      <= 1'b0;
      end
      OP_EMIT: begin
        character <= rd_byte;
        last      <= (sp == '0);
      end
      default: ;
    endcase
  end

  // stack pointer and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      sp     <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= ((op == OP_SIGN) && neg) || (op == OP_EMIT);
      unique case (op)
        OP_LOAD: sp <= '0;
        OP_FIX:  sp <= SP_BITS'(sp + 1'b1);
        OP_POP:  sp <= sp_m1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/integer_to_radix_text.sv
// integer_to_radix_text: signed integer to text in a radix set by a configured digit alphabet
// depends on itr_pkg, itr_sequencer, itr_alphabet, itr_datapath
//
// Usage: write the alphabet into registers 0..7 through cfg_we/cfg_index/cfg_data, eight
// bytes per register, lowest byte first; a zero byte ends it and its length is the radix.
// A write raises busy while the alphabet is checked and the radix reciprocal is built.
// A number is taken when start is high and busy is low. Each output word is one
// character, shown for one cycle with strobe high; last marks the final character.
// A negative number first gives '-'. An invalid alphabet gives no words at all.
// For a valid alphabet each digit is made by a multiply by the reciprocal, a multiply back,
// a correction and a test; each character then takes a stack read and an alphabet lookup
// through the single alphabet read port. There are at most NUMBER_BITS digits. With an
// invalid alphabet an accepted number is dropped at the check step, before any digit work.
// The receiver cannot stall: words are not held. Reset clears the alphabet, so the
// block comes out of reset busy for a short check and then rejects numbers until a
// valid alphabet is written.
module integer_to_radix_text
  import itr_pkg::*;
#(
  parameter int ALPHABET_BYTES = 64,
  parameter int NUMBER_BITS    = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [NUMBER_BITS-1:0] number,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  output logic [7:0]                    character,
  output logic                          last,
  output logic                          strobe
);

  pc_t                    pc;
  ctrl_t                  ctrl;
  alph_stat_t             astat;
  dp_stat_t               dstat;
  logic [ADDR_BITS-1:0]   rd_addr;
  logic [7:0]             rd_byte;
  logic [RADIX_BITS-1:0]  radix;
  logic [NUMBER_BITS-1:0] recip;

  // ready only at the accept step with a checked alphabet
  assign busy = rst || (pc != A_WAIT1) || astat.dirty;

  itr_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .astat (astat),
    .dstat (dstat),
    .pc    (pc),
    .ctrl  (ctrl)
  );

  itr_alphabet #(
    .ALPHABET_BYTES (ALPHABET_BYTES),
    .NUMBER_BITS    (NUMBER_BITS)
  ) u_alph (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (ctrl.op),
    .rd_addr   (rd_addr),
    .rd_byte   (rd_byte),
    .radix     (radix),
    .recip     (recip),
    .astat     (astat)
  );

  itr_datapath #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .number    (number),
    .op        (ctrl.op),
    .radix     (radix),
    .recip     (recip),
    .rd_byte   (rd_byte),
    .rd_addr   (rd_addr),
    .dstat     (dstat),
    .character (character),
    .last      (last),
    .strobe    (strobe)
  );

endmodule

### rtl/itr_checker.sv
// itr_checker: port level checks for integer_to_radix_text, attached by bind
// depends on the top level's ports only
module itr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cfg_we,
  input logic strobe,
  input logic last
);

  // a word only appears while a number is in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("word shown while not busy");

  // words are never back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("two words in consecutive cycles");

  // no word in the cycle right after an accept
  a_accept_gap: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !strobe)
    else $error("word right after accept");

  // a register write makes the block recheck the alphabet
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst) cfg_we |=> busy)
    else $error("not busy after a register write");

  // the final word closes the text: the next cycle is quiet and still busy
  a_last_close: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> (!strobe && busy))
    else $error("activity after final word");

endmodule

bind integer_to_radix_text itr_checker u_itr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cfg_we (cfg_we),
  .strobe (strobe),
  .last   (last)
);

### bench/tb_integer_to_radix_text.sv
// tb_integer_to_radix_text: self-checking bench for the radix text printer
// drives alphabets and numbers, predicts each character word and checks it on the strobe
// depends on itr_pkg and integer_to_radix_text
module tb_integer_to_radix_text;
  import itr_pkg::*;

  localparam int NUM_BITS     = 32;
  localparam int ALPHA_BYTES  = CFG_WORDS * 8;
  localparam int RANDOM_WORDS = 270;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_word_t;

  typedef bit [7:0] byte_q_t[$];

  // expected text of accepted numbers, spelled with a private copy of the alphabet
  class radix_text_board;
    bit [CFG_DATA_BITS-1:0] alpha_regs[CFG_WORDS];
    text_word_t             pending[$];
    int                     mismatches;
    int                     checked;

    function bit [7:0] alpha_byte(int idx);
      bit [CFG_DATA_BITS-1:0] w;
      w = alpha_regs[idx / 8] >> ((idx % 8) * 8);
      return w[7:0];
    endfunction

    function bit letter_or_digit(bit [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // alphabet length if usable, zero otherwise
    function int radix();
      int        len;
      bit [7:0]  c;
      len = 0;
      while (len < ALPHA_BYTES && alpha_byte(len) != 8'd0) len++;
      if (len < 2) return 0;
      for (int i = 0; i < len; i++) begin
        c = alpha_byte(i);
        if (!letter_or_digit(c)) return 0;
        for (int j = 0; j < i; j++)
          if (alpha_byte(j) == c) return 0;
      end
      return len;
    endfunction

    function void note_number(logic [NUM_BITS-1:0] raw);
      int                  r;
      bit [NUM_BITS-1:0]   mag;
      bit [NUM_BITS-1:0]   base;
      int                  digs[$];
      text_word_t          w;
      r = radix();
      if (r == 0) return;
      base = r;
      // the most negative value wraps to its own magnitude in unsigned bits
      mag = raw[NUM_BITS-1] ? (~raw + 1'b1) : raw;
      do begin
        digs.push_back(int'(mag % base));
        mag = mag / base;
      end while (mag != 0);
      if (raw[NUM_BITS-1]) begin
        w.character = CHAR_MINUS;
        w.last      = 1'b0;
        pending.push_back(w);
      end
      for (int k = digs.size() - 1; k >= 0; k--) begin
        w.character = alpha_byte(digs[k]);
        w.last      = (k == 0);
        pending.push_back(w);
      end
    endfunction

    function void check_char(logic [7:0] c, logic l);
      text_word_t w;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: got character %h last %b with no text expected", $time, c, l);
        return;
      end
      w = pending.pop_front();
      if (c !== w.character) begin
        mismatches++;
        $display("%0t: character expected %h got %h", $time, w.character, c);
      end
      if (l !== w.last) begin
        mismatches++;
        $display("%0t: last expected %b got %b", $time, w.last, l);
      end
    endfunction
  endclass

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       start     = 1'b0;
  logic signed [NUM_BITS-1:0] number    = '0;
  logic                       cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;
  logic                       busy;
  logic [7:0]                 character;
  logic                       last;
  logic                       strobe;

  radix_text_board board = new();
  int sent;
  int phases;

  integer_to_radix_text dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .number    (number),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .character (character),
    .last      (last),
    .strobe    (strobe)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: every strobed word is checked
  always @(posedge clk) begin
    if (!rst && strobe) board.check_char(character, last);
  end

  function automatic byte_q_t str_chars(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // all 62 letters and digits in random order
  function automatic byte_q_t alnum_shuffled();
    byte_q_t  q;
    bit [7:0] t;
    int       j;
    for (int k = 0; k < 10; k++) q.push_back(8'(8'h30 + k));
    for (int k = 0; k < 26; k++) q.push_back(8'(8'h41 + k));
    for (int k = 0; k < 26; k++) q.push_back(8'(8'h61 + k));
    for (int i = q.size() - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = q[i];
      q[i] = q[j];
      q[j] = t;
    end
    return q;
  endfunction

  // a nonzero byte that is neither letter nor digit, often right at a class boundary
  function automatic bit [7:0] odd_byte();
    bit [7:0] edges[7] = '{8'd47, 8'd58, 8'd64, 8'd91, 8'd96, 8'd123, 8'd45};
    case ($urandom_range(0, 2))
      0:       return edges[$urandom_range(0, 6)];
      1:       return 8'($urandom_range(1, 47));
      default: return 8'($urandom_range(123, 255));
    endcase
  endfunction

  function automatic logic [NUM_BITS-1:0] pick_number(int r);
    logic [NUM_BITS-1:0] v;
    case ($urandom_range(0, 4))
      0, 1: v = $urandom;
      2:    v = $urandom_range(0, 200) - 100;
      3: begin
        v = $urandom >> $urandom_range(1, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = r;
          3:       v = -r;
          4:       v = r * r - 1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  // wait out all pending text plus the tail of the last word
  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // pack the characters, a terminator if there is room, and noise behind it into the eight registers
  task automatic write_alphabet(input byte_q_t chars);
    bit [7:0]               bytes[ALPHA_BYTES];
    bit [CFG_DATA_BITS-1:0] w;
    int                     settle;
    drain();
    for (int i = 0; i < ALPHA_BYTES; i++) begin
      if (i < chars.size()) bytes[i] = chars[i];
      else if (i == chars.size()) bytes[i] = 8'd0;
      else bytes[i] = 8'($urandom_range(0, 255));
    end
    for (int r = 0; r < CFG_WORDS; r++) begin
      for (int b = 0; b < 8; b++) w[b*8 +: 8] = bytes[r*8 + b];
      while (busy) @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= r[CFG_IDX_BITS-1:0];
      cfg_data  <= w;
      @(posedge clk);
      board.alpha_regs[r] = w;
      cfg_we <= 1'b0;
      // the write kicks off an alphabet check; let it start, then let it finish
      settle = 0;
      while (!busy && settle < 4) begin
        @(posedge clk);
        settle++;
      end
    end
    while (busy) @(posedge clk);
    phases++;
  endtask

  // hold start until the block takes the word, then, unless no_gaps is set, idle a random while
  task automatic send_number(input logic [NUM_BITS-1:0] v, input bit no_gaps);
    int gap;
    start  <= 1'b1;
    number <= v;
    do @(posedge clk); while (busy);
    board.note_number(v);
    sent++;
    if (!no_gaps) begin
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 250);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stimulus
  initial begin
    byte_q_t chars;
    int      kind;
    int      len;
    int      r;
    int      j;
    int      count;
    int      valid_words;
    bit      no_gaps;

    valid_words = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty alphabet out of reset: numbers give no text
    send_number(32'd0, 1'b1);
    send_number(32'hFFFF_FFFF, 1'b0);

    // binary: longest text, including the most negative value
    write_alphabet(str_chars("01"));
    send_number(32'h8000_0000, 1'b0);
    send_number(32'h7FFF_FFFF, 1'b1);
    send_number(32'd0, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0);
    send_number(32'd1, 1'b1);

    // decimal around one and two digits, a negative and a five digit value
    write_alphabet(str_chars("0123456789"));
    send_number(32'd9, 1'b0);
    send_number(32'd10, 1'b1);
    send_number(-10, 1'b0);
    send_number(32'd12345, 1'b0);

    // widest usable alphabet, reversed order
    write_alphabet(str_chars(
      "zyxwvutsrqponmlkjihgfedcbaZYXWVUTSRQPONMLKJIHGFEDCBA9876543210"));
    send_number(32'd61, 1'b0);
    send_number(32'd62, 1'b1);
    send_number(-62, 1'b0);
    send_number(32'h8000_0000, 1'b0);

    // unusable alphabets: repeat, non-alnum, single char, no terminator
    write_alphabet(str_chars("abca"));
    send_number(-5, 1'b0);
    write_alphabet(str_chars("0:1"));
    send_number(32'd77, 1'b0);
    write_alphabet(str_chars("7"));
    send_number(32'd3, 1'b0);
    write_alphabet(str_chars(
      "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz01"));
    send_number(32'd100, 1'b0);

    // random alphabets, mostly usable, each with a run of random numbers
    while (valid_words < RANDOM_WORDS) begin
      kind  = $urandom_range(0, 9);
      chars = alnum_shuffled();
      if (kind < 7) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0:       len = 2;
            1:       len = 62;
            2:       len = 10;
            default: len = 16;
          endcase
        end else begin
          len = $urandom_range(2, 62);
        end
        chars = chars[0:len-1];
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            len      = $urandom_range(2, 62);
            chars    = chars[0:len-1];
            j        = $urandom_range(1, len - 1);
            chars[j] = chars[$urandom_range(0, j - 1)];
          end
          1: begin
            len = $urandom_range(2, 62);
            chars = chars[0:len-1];
            chars[$urandom_range(0, len - 1)] = odd_byte();
          end
          2: begin
            if ($urandom_range(0, 1)) chars.delete();
            else chars = chars[0:0];
          end
          default: begin
            chars.push_back(chars[0]);
            chars.push_back(chars[1]);
          end
        endcase
      end
      write_alphabet(chars);
      r       = board.radix();
      count   = (r != 0) ? $urandom_range(10, 30) : $urandom_range(2, 5);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (count) send_number(pick_number(r), no_gaps);
      if (r != 0) valid_words += count;
    end

    drain();
    $display("%0d numbers sent under %0d alphabet settings, %0d characters checked",
             sent, phases, board.checked);
    if (board.mismatches == 0) begin
      $display("integer_to_radix_text regression: pass");
    end else begin
      $display("integer_to_radix_text regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("integer_to_radix_text regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/itr_pkg.sv
rtl/itr_sequencer.sv
rtl/itr_alphabet.sv
rtl/itr_datapath.sv
rtl/integer_to_radix_text.sv
rtl/itr_checker.sv
bench/tb_integer_to_radix_text.sv
